/* hw/rtl/pidsrv_pkg.sv */
package pidsrv_pkg;

    localparam int FRAC_BITS = 15;
    localparam int DATA_W    = 32;
    localparam int ERROR_W   = 23;
    localparam int LEVEL_W   = 12;
    localparam int GAIN_W    = 20;
    localparam int ALPHA_W   = 16;
    localparam int LIMIT_W   = 23;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET      = 20'd10485;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET     = 20'd6553;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET     = 20'd157286;
    localparam logic [ALPHA_W-1:0] SMOOTH_ALPHA_RESET   = 16'd13107;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 23'd1310720;
    localparam logic [STEP_W-1:0]  TIME_STEP_RESET      = 16'd655;

    localparam logic signed [DATA_W-1:0] FIX_ONE =
        DATA_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [DATA_W-1:0] DERIV_MAX =
        DATA_W'(64'sd80 <<< FRAC_BITS);
    localparam logic signed [DATA_W-1:0] CONTROL_RESET =
        DATA_W'(64'sd135 <<< FRAC_BITS);
    localparam logic signed [DATA_W-1:0] LAST_CONTROL_RESET =
        DATA_W'(-(64'sd1 <<< FRAC_BITS));

    localparam int ANGLE_W      = DATA_W + 2;
    localparam int ANGLE_MIN    = 85;
    localparam int ANGLE_MAX    = 165;
    localparam int ANGLE_CENTRE = 135;
    localparam int ANGLE_SPAN   = ANGLE_MAX - ANGLE_MIN + 1;
    localparam int ANGLE_IDX_W  = $clog2(ANGLE_SPAN);

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [LEVEL_W-1:0] level_lut_t [0:ANGLE_SPAN-1];

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_SMOOTH_ALPHA   = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_TIME_STEP      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [ALPHA_W-1:0] smooth_alpha;
        logic [LIMIT_W-1:0] integral_limit;
        logic [STEP_W-1:0]  time_step;
    } pid_cfg_t;

    typedef struct packed {
        logic                     start;
        logic                     drain;
        logic                     fresh;
        logic signed [DATA_W-1:0] error;
    } lane_cmd_t;

    typedef struct packed {
        logic                     idle;
        logic                     done;
        logic                     update;
        logic signed [DATA_W-1:0] control;
    } lane_status_t;

    // The compare level for every angle in the clamped range.
    function automatic level_lut_t build_level_lut();
        level_lut_t lut;
        int pulse;
        for (int a = 0; a < ANGLE_SPAN; a++)
        begin
            pulse = 500 + ((a + ANGLE_MIN) * 2000) / 270;
            lut[a] = LEVEL_W'((pulse * 125) / 64);
        end
        return lut;
    endfunction

    localparam level_lut_t LEVEL_LUT = build_level_lut();

endpackage

/* hw/rtl/pidsrv_tick_if.sv */
interface pidsrv_tick_if import pidsrv_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [ERROR_W-1:0] error_x;
    logic signed [ERROR_W-1:0] error_y;
    logic                      fresh_error;

    modport source (output valid, output error_x, output error_y, output fresh_error,
                    input ready);
    modport sink (input valid, input error_x, input error_y, input fresh_error,
                  output ready);
endinterface

/* hw/rtl/pidsrv_level_if.sv */
interface pidsrv_level_if import pidsrv_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level_x;
    logic [LEVEL_W-1:0] level_y;
    logic               update_x;
    logic               update_y;

    modport source (output valid, output level_x, output level_y, output update_x,
                    output update_y, input ready);
    modport sink (input valid, input level_x, input level_y, input update_x,
                  input update_y, output ready);
endinterface

/* hw/rtl/pidsrv_lane.sv */
module pidsrv_lane import pidsrv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lane_cmd_t    cmd,
    input  pid_cfg_t     cfg,
    output lane_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        STEP_TS,
        STEP_PG,
        STEP_IG,
        STEP_DG,
        STEP_ALPHA,
        STEP_TOTAL,
        STEP_BETA,
        STEP_CTRL
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   fresh_reg, fresh_next;
    logic   update_reg, update_next;

    logic signed [DATA_W-1:0] error_reg, error_next;
    logic signed [DATA_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] integ_reg, integ_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic signed [DATA_W-1:0] dterm_reg, dterm_next;
    logic signed [DATA_W-1:0] control_reg, control_next;
    logic signed [DATA_W-1:0] last_reg, last_next;
    logic signed [DATA_W-1:0] pterm_reg, pterm_next;
    logic signed [DATA_W-1:0] iterm_reg, iterm_next;
    logic signed [DATA_W-1:0] total_reg, total_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;

    logic signed [DATA_W-1:0]   mul_a;
    logic signed [DATA_W-1:0]   mul_b;
    logic signed [2*DATA_W-1:0] product;
    logic signed [DATA_W-1:0]   integ_sum;
    logic signed [DATA_W-1:0]   lim_pos;
    logic signed [DATA_W-1:0]   lim_neg;
    logic signed [DATA_W-1:0]   beta;

    assign lim_pos = $signed({{(DATA_W-LIMIT_W){1'b0}}, cfg.integral_limit});
    assign lim_neg = -lim_pos;
    assign beta    = FIX_ONE - $signed({{(DATA_W-ALPHA_W){1'b0}}, cfg.smooth_alpha});
    assign integ_sum = integ_reg + prod_reg;

    always_comb
    begin
        case (step_reg)
            STEP_TS:
            begin
                mul_a = error_reg;
                mul_b = $signed({{(DATA_W-STEP_W){1'b0}}, cfg.time_step});
            end
            STEP_PG:
            begin
                mul_a = $signed({{(DATA_W-GAIN_W){1'b0}}, cfg.prop_gain});
                mul_b = error_reg;
            end
            STEP_IG:
            begin
                mul_a = integ_reg;
                mul_b = $signed({{(DATA_W-GAIN_W){1'b0}}, cfg.integ_gain});
            end
            STEP_DG:
            begin
                mul_a = error_reg - prev_reg;
                mul_b = $signed({{(DATA_W-GAIN_W){1'b0}}, cfg.deriv_gain});
            end
            STEP_ALPHA:
            begin
                mul_a = $signed({{(DATA_W-ALPHA_W){1'b0}}, cfg.smooth_alpha});
                mul_b = control_reg;
            end
            STEP_BETA:
            begin
                mul_a = beta;
                mul_b = total_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // An arithmetic shift of the full product rounds towards minus infinity.
    assign product   = mul_a * mul_b;
    assign prod_next = product[FRAC_BITS +: DATA_W];

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        fresh_next   = fresh_reg;
        update_next  = update_reg;
        error_next   = error_reg;
        integ_next   = integ_reg;
        prev_next    = prev_reg;
        dterm_next   = dterm_reg;
        control_next = control_reg;
        last_next    = last_reg;
        pterm_next   = pterm_reg;
        iterm_next   = iterm_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_TS;
                    error_next = cmd.error;
                    fresh_next = cmd.fresh;
                end
            end
            ST_RUN:
            begin
                step_next = step_t'(step_reg + 3'd1);
                case (step_reg)
                    STEP_PG:
                    begin
                        if (integ_sum > lim_pos)
                        begin
                            integ_next = lim_pos;
                        end
                        else if (integ_sum < lim_neg)
                        begin
                            integ_next = lim_neg;
                        end
                        else
                        begin
                            integ_next = integ_sum;
                        end
                    end
                    STEP_IG:
                    begin
                        pterm_next = prod_reg;
                    end
                    STEP_DG:
                    begin
                        iterm_next = prod_reg;
                    end
                    STEP_ALPHA:
                    begin
                        if (fresh_reg)
                        begin
                            prev_next = error_reg;
                            if (prod_reg > DERIV_MAX || prod_reg < -DERIV_MAX)
                            begin
                                dterm_next = '0;
                            end
                            else
                            begin
                                dterm_next = prod_reg;
                            end
                        end
                    end
                    STEP_TOTAL:
                    begin
                        total_next = pterm_reg + dterm_reg + iterm_reg;
                        acc_next   = prod_reg;
                    end
                    STEP_CTRL:
                    begin
                        control_next = acc_reg + prod_reg;
                        update_next  = (control_next != last_reg);
                        last_next    = control_next;
                        state_next   = ST_DONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DONE:
            begin
                if (cmd.drain)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_TS;
            integ_reg   <= '0;
            prev_reg    <= '0;
            dterm_reg   <= '0;
            control_reg <= CONTROL_RESET;
            last_reg    <= LAST_CONTROL_RESET;
            update_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            integ_reg   <= integ_next;
            prev_reg    <= prev_next;
            dterm_reg   <= dterm_next;
            control_reg <= control_next;
            last_reg    <= last_next;
            update_reg  <= update_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
        error_reg <= error_next;
        prod_reg  <= prod_next;
        pterm_reg <= pterm_next;
        iterm_reg <= iterm_next;
        total_reg <= total_next;
        acc_reg   <= acc_next;
    end

    assign status.idle    = (state_reg == ST_IDLE);
    assign status.done    = (state_reg == ST_DONE);
    assign status.update  = update_reg;
    assign status.control = control_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> state_reg == ST_IDLE)
        else $error("Lane started while still busy.");

    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && step_reg == STEP_CTRL) |=> status.done)
        else $error("Lane did not finish after its last step.");

    a_dterm_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        dterm_reg <= DERIV_MAX && dterm_reg >= -DERIV_MAX)
        else $error("Derivative term outside its permitted magnitude.");

endmodule

/* hw/rtl/pidsrv_merge.sv */
module pidsrv_merge import pidsrv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_status_t          status_x,
    input  lane_status_t          status_y,
    output logic                  drain,
    pidsrv_level_if.source        level
);

    logic               valid_reg;
    logic [LEVEL_W-1:0] level_x_reg;
    logic [LEVEL_W-1:0] level_y_reg;
    logic               update_x_reg;
    logic               update_y_reg;

    logic signed [DATA_W-1:0] whole_x;
    logic signed [DATA_W-1:0] whole_y;
    angle_t                   angle_x;
    angle_t                   angle_y;

    function automatic logic [ANGLE_IDX_W-1:0] angle_index(angle_t a);
        angle_t c;
        if (a > angle_t'(ANGLE_MAX))
        begin
            c = angle_t'(ANGLE_MAX);
        end
        else if (a < angle_t'(ANGLE_MIN))
        begin
            c = angle_t'(ANGLE_MIN);
        end
        else
        begin
            c = a;
        end
        return ANGLE_IDX_W'(c - angle_t'(ANGLE_MIN));
    endfunction

    // The X servo is mounted mirrored, so its angle runs the other way.
    assign whole_x = status_x.control >>> FRAC_BITS;
    assign whole_y = status_y.control >>> FRAC_BITS;
    assign angle_x = angle_t'(ANGLE_CENTRE) - {{(ANGLE_W-DATA_W){whole_x[DATA_W-1]}}, whole_x};
    assign angle_y = angle_t'(ANGLE_CENTRE) + {{(ANGLE_W-DATA_W){whole_y[DATA_W-1]}}, whole_y};

    assign drain = status_x.done && status_y.done && (!valid_reg || level.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            valid_reg <= 1'b1;
        end
        else if (level.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            level_x_reg  <= LEVEL_LUT[angle_index(angle_x)];
            level_y_reg  <= LEVEL_LUT[angle_index(angle_y)];
            update_x_reg <= status_x.update;
            update_y_reg <= status_y.update;
        end
    end

    assign level.valid    = valid_reg;
    assign level.level_x  = level_x_reg;
    assign level.level_y  = level_y_reg;
    assign level.update_x = update_x_reg;
    assign level.update_y = update_y_reg;

endmodule

/* hw/rtl/dual_axis_pid_servo_unit.sv */
// Channel   Direction  Payload                                   Transfer
// tick      in         error_x, error_y (Q7.15), fresh_error     valid and ready high
// level     out        level_x, level_y, update_x, update_y      valid and ready high
// cfg       in         cfg_index, cfg_data                       cfg_write high
//
// A tick is taken only while both axis lanes are idle; each lane then runs eight
// steps through its single 32 by 32 multiplier, so a new tick is taken only after
// the result has passed into the output register.
// The output register holds a finished result while the next tick is computed;
// a stalled output holds the lanes in their finished state until it drains.
// Reset is asynchronous and active low and restores the register and state values.
module dual_axis_pid_servo_unit import pidsrv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pidsrv_tick_if.sink           tick,
    pidsrv_level_if.source        level
);

    pid_cfg_t     pid_cfg_reg;
    lane_cmd_t    cmd_x;
    lane_cmd_t    cmd_y;
    lane_status_t status_x;
    lane_status_t status_y;
    logic         start;
    logic         drain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_cfg_reg.prop_gain      <= PROP_GAIN_RESET;
            pid_cfg_reg.integ_gain     <= INTEG_GAIN_RESET;
            pid_cfg_reg.deriv_gain     <= DERIV_GAIN_RESET;
            pid_cfg_reg.smooth_alpha   <= SMOOTH_ALPHA_RESET;
            pid_cfg_reg.integral_limit <= INTEGRAL_LIMIT_RESET;
            pid_cfg_reg.time_step      <= TIME_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PROP_GAIN:      pid_cfg_reg.prop_gain      <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:     pid_cfg_reg.integ_gain     <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:     pid_cfg_reg.deriv_gain     <= cfg_data[GAIN_W-1:0];
                REG_SMOOTH_ALPHA:   pid_cfg_reg.smooth_alpha   <= cfg_data[ALPHA_W-1:0];
                REG_INTEGRAL_LIMIT: pid_cfg_reg.integral_limit <= cfg_data[LIMIT_W-1:0];
                REG_TIME_STEP:      pid_cfg_reg.time_step      <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign tick.ready = status_x.idle && status_y.idle;
    assign start      = tick.valid && tick.ready;

    assign cmd_x.start = start;
    assign cmd_x.drain = drain;
    assign cmd_x.fresh = tick.fresh_error;
    assign cmd_x.error = {{(DATA_W-ERROR_W){tick.error_x[ERROR_W-1]}}, tick.error_x};

    assign cmd_y.start = start;
    assign cmd_y.drain = drain;
    assign cmd_y.fresh = tick.fresh_error;
    assign cmd_y.error = {{(DATA_W-ERROR_W){tick.error_y[ERROR_W-1]}}, tick.error_y};

    pidsrv_lane u_lane_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_x),
        .cfg    (pid_cfg_reg),
        .status (status_x)
    );

    pidsrv_lane u_lane_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_y),
        .cfg    (pid_cfg_reg),
        .status (status_y)
    );

    pidsrv_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .status_x (status_x),
        .status_y (status_y),
        .drain    (drain),
        .level    (level)
    );

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        status_x.done == status_y.done && status_x.idle == status_y.idle)
        else $error("Axis lanes have fallen out of step.");

    a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> !tick.ready)
        else $error("A second tick was taken while the lanes were busy.");

endmodule

/* dv/tb_top.sv */
module tb_top import pidsrv_pkg::*; ;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_x;
        logic [LEVEL_W-1:0] level_y;
        logic               update_x;
        logic               update_y;
    } servo_levels_t;

    typedef enum int {
        SET_RESET,
        SET_MODERATE,
        SET_RAW,
        SET_ALL_ONES,
        SET_ALL_ZERO
    } setting_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pidsrv_tick_if  tick_ch ();
    pidsrv_level_if level_ch ();

    dual_axis_pid_servo_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .level     (level_ch)
    );

    always #5 clk = ~clk;

    // Register copies, and controller state with one entry per axis (X first).
    int gain_p, gain_i, gain_d, alpha, int_limit, dt;
    int integ_sum [2];
    int prev_error [2];
    int deriv_term [2];
    int control [2];
    int last_control [2];

    servo_levels_t pending_levels [$];

    int error_count      = 0;
    int ticks_sent       = 0;
    int levels_checked   = 0;
    int settings_applied = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int hold_off_cycles  = 0;

    function automatic int fx_mul(input int a, input int b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return int'(prod >>> FRAC_BITS);
    endfunction

    function automatic logic [LEVEL_W-1:0] control_level(input int control_val,
                                                         input bit y_axis);
        int whole;
        int angle;
        int pulse;
        whole = control_val >>> FRAC_BITS;
        angle = y_axis ? ANGLE_CENTRE + whole : ANGLE_CENTRE - whole;
        if (angle > ANGLE_MAX)
            angle = ANGLE_MAX;
        if (angle < ANGLE_MIN)
            angle = ANGLE_MIN;
        pulse = 500 + angle * 2000 / 270;
        return LEVEL_W'(pulse * 125 / 64);
    endfunction

    function automatic servo_levels_t servo_step(input logic signed [ERROR_W-1:0] ex,
                                                 input logic signed [ERROR_W-1:0] ey,
                                                 input logic fresh);
        servo_levels_t      res;
        int                 err [2];
        int                 sum;
        int                 d;
        int                 total;
        int                 beta;
        logic [LEVEL_W-1:0] lvl [2];
        logic               upd [2];
        err[0] = ex;
        err[1] = ey;
        beta = FIX_ONE - alpha;
        for (int k = 0; k < 2; k++)
        begin
            sum = integ_sum[k] + fx_mul(err[k], dt);
            if (sum > int_limit)
                sum = int_limit;
            if (sum < -int_limit)
                sum = -int_limit;
            integ_sum[k] = sum;
            if (fresh)
            begin
                d = fx_mul(err[k] - prev_error[k], gain_d);
                if ((d < 0 ? -longint'(d) : longint'(d)) > longint'(DERIV_MAX))
                    d = 0;
                deriv_term[k] = d;
                prev_error[k] = err[k];
            end
            total = fx_mul(gain_p, err[k]) + deriv_term[k] + fx_mul(sum, gain_i);
            control[k] = fx_mul(alpha, control[k]) + fx_mul(beta, total);
            upd[k] = control[k] != last_control[k];
            last_control[k] = control[k];
            lvl[k] = control_level(control[k], k == 1);
        end
        res.level_x  = lvl[0];
        res.level_y  = lvl[1];
        res.update_x = upd[0];
        res.update_y = upd[1];
        return res;
    endfunction

    function automatic logic signed [ERROR_W-1:0] random_error(
            input logic signed [ERROR_W-1:0] last);
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return ERROR_W'(int'($urandom_range(5242880)) - 2621440);
        else if (pick < 70)
            return ERROR_W'(int'($urandom_range(8191)) - 4096);
        else if (pick < 85)
            return last;
        return ERROR_W'($urandom);
    endfunction

    function automatic void compare_field(input string name, input logic [LEVEL_W-1:0] want,
                                          input logic [LEVEL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_levels();
        servo_levels_t want;
        if (pending_levels.size() == 0)
        begin
            $error("level transfer with no tick outstanding: level_x %0d, level_y %0d",
                   level_ch.level_x, level_ch.level_y);
            error_count++;
            return;
        end
        want = pending_levels.pop_front();
        levels_checked++;
        compare_field("level_x", want.level_x, level_ch.level_x);
        compare_field("level_y", want.level_y, level_ch.level_y);
        compare_field("update_x", want.update_x, level_ch.update_x);
        compare_field("update_y", want.update_y, level_ch.update_y);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_PROP_GAIN:      gain_p    = int'(data[GAIN_W-1:0]);
            REG_INTEG_GAIN:     gain_i    = int'(data[GAIN_W-1:0]);
            REG_DERIV_GAIN:     gain_d    = int'(data[GAIN_W-1:0]);
            REG_SMOOTH_ALPHA:   alpha     = int'(data[ALPHA_W-1:0]);
            REG_INTEGRAL_LIMIT: int_limit = int'(data[LIMIT_W-1:0]);
            REG_TIME_STEP:      dt        = int'(data[STEP_W-1:0]);
            default:            ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] i,
                                  input logic [CFG_DATA_W-1:0] d, input logic [CFG_DATA_W-1:0] a,
                                  input logic [CFG_DATA_W-1:0] l, input logic [CFG_DATA_W-1:0] t);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_SMOOTH_ALPHA, a);
        write_reg(REG_INTEGRAL_LIMIT, l);
        write_reg(REG_TIME_STEP, t);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    task automatic send_tick(input logic signed [ERROR_W-1:0] ex,
                             input logic signed [ERROR_W-1:0] ey, input logic fresh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid   <= 1'b0;
            tick_ch.error_x <= ERROR_W'($urandom);
            @(posedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.error_x     <= ex;
        tick_ch.error_y     <= ey;
        tick_ch.fresh_error <= fresh;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        pending_levels.push_back(servo_step(ex, ey, fresh));
        ticks_sent++;
    endtask

    task automatic wait_for_levels();
        tick_ch.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_tick(0, 0, 1'b1);
        send_tick(23'sd2621440, -23'sd2621440, 1'b1);
        send_tick(23'sd2621440, -23'sd2621440, 1'b0);
        send_tick(-23'sd2621440, 23'sd2621440, 1'b1);
        send_tick(23'sd100, -23'sd100, 1'b1);
        send_tick(23'sd100, -23'sd100, 1'b0);
        send_tick(23'sh400000, 23'sh3FFFFF, 1'b1);
        send_tick(23'sh3FFFFF, 23'sh400000, 1'b0);
        send_tick(23'sd32768, 23'sd32768, 1'b1);
        send_tick(0, 0, 1'b0);
        send_tick(0, 0, 1'b0);
        send_tick(0, 0, 1'b1);
        wait_for_levels();
    endtask

    task automatic test_register_extremes();
        apply_settings('1, 23'hFFFFF, '0, '0, 23'd4194304, 23'd32768);
        send_tick(23'sd2621440, 23'sd2621440, 1'b1);
        send_tick(-23'sd2621440, 23'sd1000, 1'b1);
        send_tick(23'sh400000, 23'sh3FFFFF, 1'b0);
        send_tick(23'sd1, -23'sd1, 1'b1);
        send_tick(0, 0, 1'b0);
        wait_for_levels();
        apply_settings('0, '0, '1, 23'd32768, '0, 23'hFFFF);
        send_tick(23'sd2621440, -23'sd2621440, 1'b1);
        send_tick(23'sd65536, -23'sd65536, 1'b1);
        send_tick(23'sd65536, -23'sd65536, 1'b1);
        send_tick(23'sh3FFFFF, 23'sh400000, 1'b0);
        send_tick(0, 0, 1'b1);
        wait_for_levels();
    endtask

    task automatic test_random_ticks();
        logic signed [ERROR_W-1:0] ex;
        logic signed [ERROR_W-1:0] ey;
        setting_kind_t             kind;
        ex = '0;
        ey = '0;
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            kind = setting_kind_t'(phase % 5);
            case (kind)
                SET_RESET:
                    apply_settings(CFG_DATA_W'(PROP_GAIN_RESET), CFG_DATA_W'(INTEG_GAIN_RESET),
                                   CFG_DATA_W'(DERIV_GAIN_RESET),
                                   CFG_DATA_W'(SMOOTH_ALPHA_RESET),
                                   CFG_DATA_W'(INTEGRAL_LIMIT_RESET),
                                   CFG_DATA_W'(TIME_STEP_RESET));
                SET_MODERATE:
                    apply_settings(CFG_DATA_W'($urandom_range(65535)),
                                   CFG_DATA_W'($urandom_range(32767)),
                                   CFG_DATA_W'($urandom_range(262143)),
                                   CFG_DATA_W'($urandom_range(32768)),
                                   CFG_DATA_W'($urandom_range(4194304)),
                                   CFG_DATA_W'($urandom_range(32768)));
                SET_RAW:
                    apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                SET_ALL_ONES:
                    apply_settings('1, '1, '1, '1, '1, '1);
                default:
                    apply_settings('0, '0, '0, '0, '0, '0);
            endcase
            for (int n = 0; n < 144; n++)
            begin
                ex = random_error(ex);
                ey = random_error(ey);
                send_tick(ex, ey, $urandom_range(99) < 70);
                if ($urandom_range(199) == 0)
                    wait_for_levels();
            end
            wait_for_levels();
        end
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 300;
        for (int n = 0; n < 12; n++)
            send_tick(random_error(0), random_error(0), 1'($urandom_range(1)));
        wait_for_levels();
    endtask

    initial
    begin
        level_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (level_ch.valid && level_ch.ready)
                check_levels();
            if (hold_off_cycles > 0)
            begin
                level_ch.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                level_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_write           <= 1'b0;
        cfg_index           <= REG_PROP_GAIN;
        cfg_data            <= '0;
        tick_ch.valid       <= 1'b0;
        tick_ch.error_x     <= '0;
        tick_ch.error_y     <= '0;
        tick_ch.fresh_error <= 1'b0;
        gain_p    = PROP_GAIN_RESET;
        gain_i    = INTEG_GAIN_RESET;
        gain_d    = DERIV_GAIN_RESET;
        alpha     = SMOOTH_ALPHA_RESET;
        int_limit = INTEGRAL_LIMIT_RESET;
        dt        = TIME_STEP_RESET;
        for (int k = 0; k < 2; k++)
        begin
            integ_sum[k]    = 0;
            prev_error[k]   = 0;
            deriv_term[k]   = 0;
            control[k]      = CONTROL_RESET;
            last_control[k] = LAST_CONTROL_RESET;
        end
        send_idle_pct = 7;
        recv_idle_pct = 59;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_ticks();
        test_output_stall();

        $display("Ran %0d ticks, %0d level transfers checked, %0d register settings.",
                 ticks_sent, levels_checked, settings_applied);
        $display("Stale and fresh errors, derivative cut-off, register extremes, stall.");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/pidsrv_pkg.sv
hw/rtl/pidsrv_tick_if.sv
hw/rtl/pidsrv_level_if.sv
hw/rtl/pidsrv_lane.sv
hw/rtl/pidsrv_merge.sv
hw/rtl/dual_axis_pid_servo_unit.sv
dv/tb_top.sv
